@@ rtl/gtepd_pkg.sv @@
// Package for the gate, trigger and end-of-phrase detector.
// It holds the widths, the reset values of the registers and the register index codes.
// It has no dependencies.
`default_nettype none

package gtepd_pkg;

  localparam int unsigned SAMPLE_WIDTH = 16;
  localparam int unsigned COUNT_WIDTH  = 16;
  localparam int unsigned THRESH_WIDTH = 15;

  localparam int unsigned MAG_WIDTH = SAMPLE_WIDTH - 1;
  localparam int unsigned CMP_WIDTH = (MAG_WIDTH > THRESH_WIDTH) ? MAG_WIDTH : THRESH_WIDTH;
  localparam int unsigned CFG_DATA_WIDTH =
      (COUNT_WIDTH > THRESH_WIDTH) ? COUNT_WIDTH : THRESH_WIDTH;
  localparam int unsigned CFG_INDEX_WIDTH = 2;

  localparam logic [THRESH_WIDTH-1:0] GATE_THRESH_RESET = THRESH_WIDTH'(3277);
  localparam logic [THRESH_WIDTH-1:0] TRIG_THRESH_RESET = THRESH_WIDTH'(16384);
  localparam logic [COUNT_WIDTH-1:0]  PULSE_LEN_RESET   = COUNT_WIDTH'(48);
  localparam logic [COUNT_WIDTH-1:0]  MIN_SILENCE_RESET = COUNT_WIDTH'(4800);

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    RegGateThreshold    = 2'd0,
    RegTriggerThreshold = 2'd1,
    RegPulseLength      = 2'd2,
    RegMinSilence       = 2'd3
  } cfg_reg_e;

endpackage

`default_nettype wire

@@ rtl/gate_trigger_end_of_phrase_detector.sv @@
// Top level of the gate, trigger and end-of-phrase detector.
// Uses gtepd_pkg for widths, reset values and register index codes.
`default_nettype none

// The block accepts one signed sample per clock cycle while the input is not stalled,
// and returns one request with the gate, trigger and end-of-phrase flags for that
// sample. A sample passes an input register and then the result register, which holds
// its flags on the outputs until they are taken; the detector state is updated as the
// sample leaves the input register. The input stalls only while both registers are
// full and the result is stalled. Configuration writes are always ready and take effect
// for samples that leave the input register after the write; they are meant to be made
// while no sample is in flight.
module gate_trigger_end_of_phrase_detector (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire logic signed [gtepd_pkg::SAMPLE_WIDTH-1:0] sample_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output logic                                       gate_o,
  output logic                                       trigger_o,
  output logic                                       end_of_phrase_o,
  input  wire logic                                  cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire logic [gtepd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index_i,
  input  wire logic [gtepd_pkg::CFG_DATA_WIDTH-1:0]  cfg_data_i
);

  localparam int unsigned SW = gtepd_pkg::SAMPLE_WIDTH;
  localparam int unsigned CW = gtepd_pkg::COUNT_WIDTH;
  localparam int unsigned TW = gtepd_pkg::THRESH_WIDTH;
  localparam int unsigned MW = gtepd_pkg::MAG_WIDTH;
  localparam int unsigned KW = gtepd_pkg::CMP_WIDTH;

  // Configuration registers.
  logic [TW-1:0] gate_thr_q, trig_thr_q;
  logic [CW-1:0] pulse_len_q, min_silence_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_thr_q    <= gtepd_pkg::GATE_THRESH_RESET;
      trig_thr_q    <= gtepd_pkg::TRIG_THRESH_RESET;
      pulse_len_q   <= gtepd_pkg::PULSE_LEN_RESET;
      min_silence_q <= gtepd_pkg::MIN_SILENCE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (gtepd_pkg::cfg_reg_e'(cfg_index_i))
        gtepd_pkg::RegGateThreshold:    gate_thr_q    <= cfg_data_i[TW-1:0];
        gtepd_pkg::RegTriggerThreshold: trig_thr_q    <= cfg_data_i[TW-1:0];
        gtepd_pkg::RegPulseLength:      pulse_len_q   <= cfg_data_i[CW-1:0];
        gtepd_pkg::RegMinSilence:       min_silence_q <= cfg_data_i[CW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control: the result register can load when empty or being taken.
  logic          s1_valid_q;
  logic [SW-1:0] s1_sample_q;
  logic          out_free;
  logic          s1_advance;
  logic          in_accept;

  assign out_free   = !out_valid_o || !out_stall_i;
  assign s1_advance = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_sample_q <= sample_i;
    end
  end

  // Magnitude with saturation of the most negative sample.
  logic [SW-1:0] neg_sample;
  logic [MW-1:0] mag;
  logic [KW-1:0] mag_k, gate_thr_k, trig_thr_k;

  assign neg_sample = (~s1_sample_q) + SW'(1);

  always_comb begin
    if (!s1_sample_q[SW-1]) begin
      mag = s1_sample_q[MW-1:0];
    end else if (neg_sample[SW-1]) begin
      mag = {MW{1'b1}};
    end else begin
      mag = neg_sample[MW-1:0];
    end
  end

  assign mag_k      = KW'(mag);
  assign gate_thr_k = KW'(gate_thr_q);
  assign trig_thr_k = KW'(trig_thr_q);

  // Detector state.
  logic          was_above_q, was_above_d;
  logic [CW-1:0] trig_rem_q, trig_rem_d;
  logic          in_peak_q, in_peak_d;
  logic [CW-1:0] silence_q, silence_d;
  logic [CW-1:0] eop_rem_q, eop_rem_d;

  logic          gate_d, trigger_d, eop_d;
  logic          above;
  logic [CW-1:0] trig_load, eop_load, silence_inc;

  always_comb begin
    gate_d      = mag_k > gate_thr_k;
    above       = mag_k > trig_thr_k;
    was_above_d = above;

    trig_load  = (above && !was_above_q) ? pulse_len_q : trig_rem_q;
    trigger_d  = trig_load != '0;
    trig_rem_d = trigger_d ? trig_load - CW'(1) : trig_load;

    in_peak_d   = in_peak_q;
    silence_d   = silence_q;
    eop_load    = eop_rem_q;
    silence_inc = (silence_q != {CW{1'b1}}) ? silence_q + CW'(1) : silence_q;
    if (in_peak_q) begin
      if (mag_k < gate_thr_k) begin
        silence_d = silence_inc;
        if (silence_inc >= min_silence_q) begin
          in_peak_d = 1'b0;
          eop_load  = pulse_len_q;
        end
      end else begin
        silence_d = '0;
      end
    end else if (gate_d) begin
      in_peak_d = 1'b1;
      silence_d = '0;
    end

    eop_d     = eop_load != '0;
    eop_rem_d = eop_d ? eop_load - CW'(1) : eop_load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      was_above_q <= 1'b0;
      trig_rem_q  <= '0;
      in_peak_q   <= 1'b0;
      silence_q   <= '0;
      eop_rem_q   <= '0;
    end else if (s1_advance) begin
      was_above_q <= was_above_d;
      trig_rem_q  <= trig_rem_d;
      in_peak_q   <= in_peak_d;
      silence_q   <= silence_d;
      eop_rem_q   <= eop_rem_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_free) begin
      out_valid_o <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance) begin
      gate_o          <= gate_d;
      trigger_o       <= trigger_d;
      end_of_phrase_o <= eop_d;
    end
  end

endmodule

`default_nettype wire
